[sv/urc_pkg.sv]
// shared types and constants of the two-channel ultrasonic ranging controller
// no dependencies; imported by the top, datapath and controller modules, not by the divider
`default_nettype none

package urc_pkg;

  // stream and configuration widths
  localparam int unsigned IN_W       = 8;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIST_W     = 24;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned DIVR_W     = 16;
  localparam int unsigned OFF_W      = 8;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TRIGGER_TICKS = 2'd0,
    REG_DIVISOR       = 2'd1,
    REG_OFFSET        = 2'd2
  } urc_reg_t;

  // register reset values
  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd15;
  localparam logic [DIVR_W-1:0] DIVISOR_RST       = 16'd87;
  localparam logic [OFF_W-1:0]  OFFSET_RST        = 8'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // result word, packed from the highest bit down
  typedef struct packed {
    logic [3:0]        pad;
    logic [DIST_W-1:0] distance;
    logic              done_res;
    logic              busy_res;
    logic              trigger_b;
    logic              trigger_a;
  } urc_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic chan_load;
    logic trig_load;
    logic trig_inc;
    logic pulse_clr;
    logic pulse_inc;
    logic div_start;
    logic dist_load;
    logic out_load;
    logic out_trig;
    logic out_busy;
    logic out_done;
  } urc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic echo_sel;
    logic trig_done;
    logic div_done;
  } urc_sts_t;

endpackage

`default_nettype wire

[sv/ultrasonic_range_controller.sv]
// two-channel ultrasonic ranging controller, one request per timer tick
// ordinary ticks are answered in the cycle after the request; the tick that
//   ends an echo waits for the one-bit-per-cycle divider before the result is loaded
// throughput: one request per cycle while the result stream is not stalled, except after
//   an echo end, which holds the input until the divider is done and its result is loaded
// reset: synchronous active-low rst_n; registers return to 15, 87 and 2, phase idle
`default_nettype none

module ultrasonic_range_controller #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [urc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [urc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // tick request stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [urc_pkg::IN_W-1:0]       in_tdata,  // start_req, channel, echo_a, echo_b
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [urc_pkg::OUT_W-1:0]           out_tdata  // trigger_a, trigger_b, busy_res,
                                                         // done_res, distance[23:0]
);

  import urc_pkg::*;

  urc_cmd_t cmd;
  urc_sts_t sts;
  urc_out_t out_data;

  urc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .start_req  (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  urc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .channel   (in_tdata[1]),
    .echo_a    (in_tdata[2]),
    .echo_b    (in_tdata[3]),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  assign out_tdata = out_data;

endmodule

`default_nettype wire

[sv/urc_div.sv]
// restoring divider, one quotient bit per cycle
// depends on nothing outside this file
`default_nettype none

module urc_div #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // one shift-and-subtract step
  always_comb begin
    rem_sh   = {rem_r, nq_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_nxt  = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
    nq_nxt   = {nq_r[NUM_W-2:0], ge};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      nq_r  <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

`default_nettype wire

[sv/urc_dp.sv]
// datapath: configuration registers, counters, divider and result register
// depends on urc_pkg and urc_div
`default_nettype none

module urc_dp #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [urc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [urc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              channel,
  input  wire logic                              echo_a,
  input  wire logic                              echo_b,
  input  wire urc_pkg::urc_cmd_t                 cmd,
  output urc_pkg::urc_sts_t                      sts,
  output urc_pkg::urc_out_t                      out_data
);

  import urc_pkg::*;

  localparam int unsigned NUM_W = COUNT_WIDTH + 2;
  localparam int unsigned DEN_W = DIVR_W + 1;
  localparam int unsigned WQ    = (NUM_W > DIST_W) ? NUM_W : DIST_W;

  logic [TRIG_W-1:0]      trig_ticks_r;
  logic [DIVR_W-1:0]      divisor_r;
  logic [OFF_W-1:0]       offset_r;
  logic                   chan_r;
  logic [TRIG_W-1:0]      trig_cnt_r;
  logic [COUNT_WIDTH-1:0] pulse_r;
  logic [DIST_W-1:0]      last_dist_r;
  urc_out_t               out_r;

  logic [TRIG_W-1:0] tt_eff;
  logic [DIVR_W-1:0] d_eff;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic              div_done;
  logic [NUM_W-1:0]  quo;
  logic [WQ-1:0]     q_ext;
  logic [WQ-1:0]     diff;
  logic [DIST_W-1:0] dist_calc;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= TRIGGER_TICKS_RST;
      divisor_r    <= DIVISOR_RST;
      offset_r     <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TRIGGER_TICKS: trig_ticks_r <= cfg_wdata[TRIG_W-1:0];
        REG_DIVISOR:       divisor_r    <= cfg_wdata[DIVR_W-1:0];
        REG_OFFSET:        offset_r     <= cfg_wdata[OFF_W-1:0];
        default:           ;
      endcase
    end
  end

  // zero trigger-tick and divisor settings behave as one
  assign tt_eff = (trig_ticks_r == '0) ? TRIG_W'(1) : trig_ticks_r;
  assign d_eff  = (divisor_r == '0) ? DIVR_W'(1) : divisor_r;

  // status back to the controller
  assign sts.echo_sel  = chan_r ? echo_b : echo_a;
  assign sts.trig_done = (trig_cnt_r >= tt_eff);
  assign sts.div_done  = div_done;

  // channel, trigger and pulse counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= 1'b0;
      trig_cnt_r <= '0;
      pulse_r    <= '0;
    end else begin
      if (cmd.chan_load) begin
        chan_r <= channel;
      end
      if (cmd.trig_load) begin
        trig_cnt_r <= TRIG_W'(1);
      end else if (cmd.trig_inc) begin
        trig_cnt_r <= trig_cnt_r + 1'b1;
      end
      if (cmd.pulse_clr) begin
        pulse_r <= '0;
      end else if (cmd.pulse_inc && !(&pulse_r)) begin
        pulse_r <= pulse_r + 1'b1;
      end
    end
  end

  // rounded quotient (2*count + d) / (2*d)
  assign num = {1'b0, pulse_r, 1'b0} + NUM_W'(d_eff);
  assign den = {d_eff, 1'b0};

  urc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // offset subtract, clamp at zero and at full scale
  always_comb begin
    q_ext = WQ'(quo);
    diff  = q_ext - WQ'(offset_r);
    if (q_ext <= WQ'(offset_r)) begin
      dist_calc = '0;
    end else if (diff > WQ'(DIST_MAX)) begin
      dist_calc = DIST_MAX;
    end else begin
      dist_calc = DIST_W'(diff);
    end
  end

  // last distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= '0;
    end else if (cmd.dist_load) begin
      last_dist_r <= dist_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.pad       <= '0;
      out_r.distance  <= cmd.dist_load ? dist_calc : last_dist_r;
      out_r.done_res  <= cmd.out_done;
      out_r.busy_res  <= cmd.out_busy;
      out_r.trigger_b <= cmd.out_trig && chan_r;
      out_r.trigger_a <= cmd.out_trig && !chan_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[sv/urc_ctrl.sv]
// controller: measurement phase machine, item sequencing and stream handshake
// depends on urc_pkg
`default_nettype none

module urc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              start_req,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire urc_pkg::urc_sts_t sts,
  output urc_pkg::urc_cmd_t      cmd
);

  import urc_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_WAIT_LOW  = 5'b00010,
    PH_TRIGGER   = 5'b00100,
    PH_WAIT_HIGH = 5'b01000,
    PH_COUNT     = 5'b10000
  } urc_phase_t;

  typedef enum logic [1:0] {
    SQ_READY = 2'b01,
    SQ_DIV   = 2'b10
  } urc_seq_t;

  urc_phase_t phase_r, phase_nxt;
  urc_seq_t   seq_r, seq_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       echo_end;

  assign in_tready = (seq_r == SQ_READY) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // next phase and commands
  always_comb begin
    cmd           = '0;
    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    echo_end      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (seq_r)
      SQ_READY: begin
        if (in_fire) begin
          case (phase_r)
            PH_IDLE: begin
              if (start_req) begin
                cmd.chan_load = 1'b1;
                phase_nxt     = PH_WAIT_LOW;
              end
            end
            PH_WAIT_LOW: begin
              if (!sts.echo_sel) begin
                cmd.trig_load = 1'b1;
                phase_nxt     = PH_TRIGGER;
              end
            end
            PH_TRIGGER: begin
              if (sts.trig_done) begin
                phase_nxt = PH_WAIT_HIGH;
              end else begin
                cmd.trig_inc = 1'b1;
              end
            end
            PH_WAIT_HIGH: begin
              if (sts.echo_sel) begin
                cmd.pulse_clr = 1'b1;
                phase_nxt     = PH_COUNT;
              end
            end
            PH_COUNT: begin
              if (sts.echo_sel) begin
                cmd.pulse_inc = 1'b1;
              end else begin
                echo_end      = 1'b1;
                cmd.div_start = 1'b1;
                phase_nxt     = PH_IDLE;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
          // echo end waits for the divider, other ticks answer at once
          if (echo_end) begin
            seq_nxt = SQ_DIV;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_trig = (phase_nxt == PH_TRIGGER);
            cmd.out_busy = (phase_nxt != PH_IDLE);
          end
        end
      end
      SQ_DIV: begin
        if (sts.div_done) begin
          cmd.dist_load = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_done  = 1'b1;
          seq_nxt       = SQ_READY;
        end
      end
      default: begin
        seq_nxt = SQ_READY;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seq_r       <= SQ_READY;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
